/* hdl/particle_pool_physics_step_macros.svh */
// Assertion macros for the particle pool block.
// Used by the top level; depends on nothing else.
`ifndef PARTICLE_POOL_PHYSICS_STEP_MACROS_SVH
`define PARTICLE_POOL_PHYSICS_STEP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define PPS_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PPS_ASSERT_NXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

/* hdl/pps_pkg.sv */
// Package for the particle pool block: payload structs, codes, constants.
// Depends on nothing.
package pps_pkg;
	localparam int PoolSlots = 256;
	localparam int SlotW = $clog2(PoolSlots);
	localparam int CntW = $clog2(PoolSlots + 1);

	localparam logic [1:0] ACT_SPAWN = 2'd0;
	localparam logic [1:0] ACT_TICK = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;
	localparam logic [1:0] ACT_NONE = 2'd3;

	localparam logic [1:0] KIND_MUZZLE = 2'd0;
	localparam logic [1:0] KIND_SPARK = 2'd1;
	localparam logic [1:0] KIND_SMOKE = 2'd2;
	localparam logic [1:0] KIND_DEBRIS = 2'd3;

	localparam logic signed [23:0] FLOOR_Q12 = 24'sd205;
	localparam logic signed [23:0] BOUNCE_Q12 = -24'sd1434;
	localparam logic signed [23:0] DAMP_Q12 = 24'sd2867;
	localparam logic [12:0] DRAG_Q12 = 13'd6554;
	localparam logic signed [23:0] S24_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] S24_MIN = -24'sh800000;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] slot;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [23:0] pos_z;
		logic signed [23:0] vel_x;
		logic signed [23:0] vel_y;
		logic signed [23:0] vel_z;
		logic [31:0] color;
		logic [15:0] time_value;
		logic [15:0] size;
		logic [1:0] kind;
	} pps_in_t;

	typedef struct packed {
		logic accepted;
		logic [7:0] slot_out;
		logic alive;
		logic [8:0] alive_count;
		logic signed [23:0] pos_x_out;
		logic signed [23:0] pos_y_out;
		logic signed [23:0] pos_z_out;
		logic [31:0] color_out;
		logic [15:0] life_out;
		logic [15:0] size_out;
		logic [1:0] kind_out;
	} pps_out_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_FIND, ST_RD, ST_RDW, ST_TLOAD, ST_TLIFE, ST_MUL,
		ST_MULW, ST_WB, ST_DONE
	} pps_state_t;

	// Saturate a 49-bit signed value to 24 bits.
	function automatic logic signed [23:0] sat24(input logic signed [48:0] v);
		if (v > 49'(S24_MAX)) return S24_MAX;
		if (v < 49'(S24_MIN)) return S24_MIN;
		return v[23:0];
	endfunction
endpackage

/* hdl/particle_pool_physics_step.sv */
// Particle pool with fixed-point Euler integration, one shared multiplier.
// A read returns one slot; a spawn fills the lowest free slot, or is refused
// when the pool is full; a tick walks every slot, expiring, dragging (smoke),
// moving and bouncing particles. One item at a time, busy high meanwhile;
// drag, integration and bounce steps share the 24x24 multiplier.
// Reset clears flags, count and sequencer; slot memories hold data until written.
`include "particle_pool_physics_step_macros.svh"
module particle_pool_physics_step (
	input logic clk,
	input logic arst_n,
	input logic start,
	input pps_pkg::pps_in_t in_item,
	output logic busy,
	output logic result_valid,
	output pps_pkg::pps_out_t result
);
	import pps_pkg::*;

	// Slot memories: one write and one registered read port each.
	logic [71:0] pos_mem [PoolSlots];
	logic [71:0] vel_mem [PoolSlots];
	logic [31:0] col_mem [PoolSlots];
	logic [15:0] life_mem [PoolSlots];
	logic [15:0] size_mem [PoolSlots];
	logic [1:0] kind_mem [PoolSlots];
	logic [PoolSlots-1:0] act_q;
	logic [CntW-1:0] total_q;

	pps_state_t state_q, state_d;
	pps_in_t item_q;
	logic [CntW-1:0] idx_q;
	logic [SlotW-1:0] ra;
	logic [71:0] pos_rd, vel_rd;
	logic [31:0] col_rd;
	logic [15:0] life_rd, size_rd;
	logic [1:0] kind_rd;

	// Working copy of one particle during a tick.
	logic signed [23:0] p_q [3];
	logic signed [23:0] v_q [3];
	logic [15:0] life_q;
	logic [1:0] kind_q;
	logic [3:0] op_q;
	logic signed [48:0] prod_q;
	logic bounce_q;
	pps_out_t res_q, res_d;
	logic rv_q;

	logic signed [23:0] ma, mb;
	logic signed [48:0] rnd;
	logic signed [24:0] fdrag;
	logic [29:0] dtd;
	logic falls;

	assign falls = (kind_q == KIND_SPARK) || (kind_q == KIND_DEBRIS);
	assign dtd = 30'(DRAG_Q12) * 30'(item_q.time_value) + 30'd2048;
	assign fdrag = 25'sd4096 - 25'(dtd[29:12]);
	assign ra = idx_q[SlotW-1:0];

	// Operand select for the shared multiplier. Ops: 0-2 drag, 3-5
	// integrate, 6-8 bounce (y, x, z).
	always_comb begin
		ma = v_q[0];
		mb = 24'(fdrag);
		case (op_q)
			4'd0, 4'd1, 4'd2: begin
				ma = v_q[op_q[1:0]];
				mb = 24'(fdrag);
			end
			4'd3, 4'd4, 4'd5: begin
				ma = v_q[2'(op_q - 4'd3)];
				mb = 24'(item_q.time_value);
			end
			4'd6: begin
				ma = v_q[1];
				mb = BOUNCE_Q12;
			end
			4'd7: begin
				ma = v_q[0];
				mb = DAMP_Q12;
			end
			default: begin
				ma = v_q[2];
				mb = DAMP_Q12;
			end
		endcase
	end

	assign rnd = (prod_q + 49'sd2048) >>> 12;

	always_ff @(posedge clk) begin
		pos_rd <= pos_mem[ra];
		vel_rd <= vel_mem[ra];
		col_rd <= col_mem[ra];
		life_rd <= life_mem[ra];
		size_rd <= size_mem[ra];
		kind_rd <= kind_mem[ra];
		prod_q <= 49'(ma * mb);
		if (state_q == ST_FIND && !act_q[ra]) begin
			pos_mem[ra] <= {item_q.pos_x, item_q.pos_y, item_q.pos_z};
			vel_mem[ra] <= {item_q.vel_x, item_q.vel_y, item_q.vel_z};
			col_mem[ra] <= item_q.color;
			life_mem[ra] <= item_q.time_value;
			size_mem[ra] <= item_q.size;
			kind_mem[ra] <= item_q.kind;
		end
		if (state_q == ST_WB) begin
			pos_mem[ra] <= {p_q[0], p_q[1], p_q[2]};
			vel_mem[ra] <= {v_q[0], v_q[1], v_q[2]};
			life_mem[ra] <= life_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (start) begin
				unique case (in_item.action)
					ACT_SPAWN: state_d = ST_FIND;
					ACT_TICK: state_d = ST_TLOAD;
					ACT_READ: state_d = ST_RD;
					default: state_d = ST_DONE;
				endcase
			end
			ST_FIND: if (!act_q[ra] || idx_q == CntW'(PoolSlots - 1)) state_d = ST_DONE;
			ST_RD: state_d = ST_RDW;
			ST_RDW: state_d = ST_DONE;
			ST_TLOAD: begin
				if (idx_q == CntW'(PoolSlots)) state_d = ST_DONE;
				else if (act_q[ra]) state_d = ST_TLIFE;
			end
			ST_TLIFE: state_d = ST_MUL;
			ST_MUL: state_d = ST_MULW;
			ST_MULW: state_d = ST_MUL;
			ST_WB: state_d = ST_TLOAD;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
		if (state_q == ST_TLIFE && item_q.time_value >= life_rd) state_d = ST_TLOAD;
		// By the last integrate step the y position is already updated.
		if (state_q == ST_MULW && (op_q == 4'd5 && !(falls &&
			p_q[1] < FLOOR_Q12) || op_q == 4'd8))
			state_d = ST_WB;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= '0;
			total_q <= '0;
			rv_q <= 1'b0;
			idx_q <= '0;
			op_q <= '0;
		end else begin
			rv_q <= (state_q == ST_DONE);
			unique case (state_q)
				ST_IDLE: begin
					idx_q <= (start && in_item.action == ACT_READ &&
						CntW'(in_item.slot) < CntW'(PoolSlots))
						? CntW'(in_item.slot) : '0;
				end
				ST_FIND: begin
					if (!act_q[ra]) begin
						act_q[ra] <= 1'b1;
						total_q <= total_q + 1'b1;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_TLOAD: if (!act_q[ra] && idx_q != CntW'(PoolSlots)) idx_q <= idx_q + 1'b1;
				ST_TLIFE: begin
					if (item_q.time_value >= life_rd) begin
						act_q[ra] <= 1'b0;
						total_q <= total_q - 1'b1;
						idx_q <= idx_q + 1'b1;
					end
					op_q <= (kind_rd == KIND_SMOKE) ? 4'd0 : 4'd3;
				end
				ST_MULW: op_q <= op_q + 1'b1;
				ST_WB: idx_q <= idx_q + 1'b1;
				default: ;
			endcase
		end
	end

	// Result assembly. A spawn that ran off the end of the pool leaves the
	// index at PoolSlots; otherwise the index is the slot just filled.
	always_comb begin
		res_d = '0;
		res_d.alive_count = 9'(total_q);
		unique case (item_q.action)
			ACT_SPAWN: begin
				if (idx_q != CntW'(PoolSlots)) begin
					res_d.accepted = 1'b1;
					res_d.alive = 1'b1;
					res_d.slot_out = 8'(idx_q);
				end
			end
			ACT_TICK: res_d.accepted = 1'b1;
			ACT_READ: begin
				res_d.accepted = 1'b1;
				res_d.slot_out = item_q.slot;
				if (CntW'(item_q.slot) < CntW'(PoolSlots) && act_q[ra]) begin
					res_d.alive = 1'b1;
					res_d.pos_x_out = pos_rd[71:48];
					res_d.pos_y_out = pos_rd[47:24];
					res_d.pos_z_out = pos_rd[23:0];
					res_d.color_out = col_rd;
					res_d.life_out = life_rd;
					res_d.size_out = size_rd;
					res_d.kind_out = kind_rd;
				end
			end
			default: ;
		endcase
	end

	// Tick datapath and result register.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) item_q <= in_item;
		if (state_q == ST_TLIFE) begin
			life_q <= life_rd - item_q.time_value;
			kind_q <= kind_rd;
			p_q[0] <= pos_rd[71:48];
			p_q[1] <= pos_rd[47:24];
			p_q[2] <= pos_rd[23:0];
			v_q[0] <= vel_rd[71:48];
			v_q[2] <= vel_rd[23:0];
			if (kind_rd == KIND_SPARK || kind_rd == KIND_DEBRIS)
				v_q[1] <= sat24(49'(signed'(vel_rd[47:24])) -
					49'(signed'({1'b0, item_q.time_value, 4'd0})));
			else
				v_q[1] <= vel_rd[47:24];
		end
		if (state_q == ST_MULW) begin
			case (op_q)
				4'd0, 4'd1, 4'd2: v_q[op_q[1:0]] <= sat24(rnd);
				4'd3, 4'd4: p_q[2'(op_q - 4'd3)] <= sat24(49'(p_q[2'(op_q - 4'd3)]) + rnd);
				4'd5: begin
					p_q[2] <= sat24(49'(p_q[2]) + rnd);
					if (falls && p_q[1] < FLOOR_Q12) p_q[1] <= FLOOR_Q12;
				end
				4'd6: v_q[1] <= sat24(rnd);
				4'd7: v_q[0] <= sat24(rnd);
				default: v_q[2] <= sat24(rnd);
			endcase
		end
		if (state_q == ST_DONE) res_q <= res_d;
	end

	assign busy = (state_q != ST_IDLE);
	assign result_valid = rv_q;
	assign result = res_q;

	`PPS_ASSERT_NXT(a_done_strobe, clk, arst_n, state_q == ST_DONE, result_valid)
	`PPS_ASSERT_IMP(a_count_max, clk, arst_n, 1'b1, total_q <= CntW'(PoolSlots))
	`PPS_ASSERT_IMP(a_strobe_idle, clk, arst_n, result_valid, state_q == ST_IDLE)
	`PPS_ASSERT_IMP(a_op_range, clk, arst_n, state_q == ST_MULW, op_q <= 4'd8)
endmodule

/* sim/pps_checker.sv */
// Checker for the particle pool block: watches the command and result beats,
// predicts each result from its own copy of the pool, and counts mismatches.
// Depends on pps_pkg for the payload structs and the action and kind codes.
`timescale 1ns / 100ps
module pps_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input pps_pkg::pps_in_t in_item,
	input logic result_valid,
	input pps_pkg::pps_out_t result,
	output int unsigned fail_count,
	output int unsigned pending
);
	import pps_pkg::*;

	localparam longint GravPerDt = 16;

	logic slot_live[PoolSlots];
	logic signed [23:0] slot_pos[PoolSlots][3];
	logic signed [23:0] slot_vel[PoolSlots][3];
	logic [31:0] slot_color[PoolSlots];
	logic [15:0] slot_life[PoolSlots];
	logic [15:0] slot_size[PoolSlots];
	logic [1:0] slot_kind[PoolSlots];
	int unsigned live_total;
	pps_out_t expected_results[$];

	assign pending = expected_results.size();

	function automatic logic signed [23:0] clamp24(longint x);
		if (x > 64'sd8388607) return S24_MAX;
		if (x < -64'sd8388608) return S24_MIN;
		return x[23:0];
	endfunction

	// Q.12 product rounded half up; the arithmetic shift is a floor.
	function automatic longint qmul(longint a, longint b);
		return (a * b + 2048) >>> 12;
	endfunction

	// Advance one active slot by dt.
	task automatic advance_slot(int i, logic [15:0] dt);
		logic falls;
		longint drag;
		falls = (slot_kind[i] == KIND_SPARK) || (slot_kind[i] == KIND_DEBRIS);
		if (dt >= slot_life[i]) begin
			slot_live[i] = 1'b0;
			live_total--;
			return;
		end
		slot_life[i] = slot_life[i] - dt;
		if (falls) begin
			slot_vel[i][1] = clamp24(longint'(slot_vel[i][1]) - GravPerDt * longint'(dt));
		end else if (slot_kind[i] == KIND_SMOKE) begin
			// The drag factor stays signed; a long step flips the velocity.
			drag = 4096 - ((longint'(DRAG_Q12) * longint'(dt) + 2048) >>> 12);
			for (int j = 0; j < 3; j++)
				slot_vel[i][j] = clamp24(qmul(slot_vel[i][j], drag));
		end
		for (int j = 0; j < 3; j++)
			slot_pos[i][j] = clamp24(longint'(slot_pos[i][j]) + qmul(slot_vel[i][j], dt));
		if (falls && slot_pos[i][1] < FLOOR_Q12) begin
			slot_pos[i][1] = FLOOR_Q12;
			slot_vel[i][1] = clamp24(qmul(slot_vel[i][1], BOUNCE_Q12));
			slot_vel[i][0] = clamp24(qmul(slot_vel[i][0], DAMP_Q12));
			slot_vel[i][2] = clamp24(qmul(slot_vel[i][2], DAMP_Q12));
		end
	endtask

	task automatic predict_pool(input pps_in_t it, output pps_out_t r);
		int i;
		r = '0;
		case (it.action)
			ACT_SPAWN: begin
				for (i = 0; i < PoolSlots; i++)
					if (!slot_live[i]) break;
				if (i < PoolSlots) begin
					slot_pos[i][0] = it.pos_x;
					slot_pos[i][1] = it.pos_y;
					slot_pos[i][2] = it.pos_z;
					slot_vel[i][0] = it.vel_x;
					slot_vel[i][1] = it.vel_y;
					slot_vel[i][2] = it.vel_z;
					slot_color[i] = it.color;
					slot_life[i] = it.time_value;
					slot_size[i] = it.size;
					slot_kind[i] = it.kind;
					slot_live[i] = 1'b1;
					live_total++;
					r.accepted = 1'b1;
					r.slot_out = i[7:0];
					r.alive = 1'b1;
				end
			end
			ACT_TICK: begin
				for (i = 0; i < PoolSlots; i++)
					if (slot_live[i]) advance_slot(i, it.time_value);
				r.accepted = 1'b1;
			end
			ACT_READ: begin
				r.accepted = 1'b1;
				r.slot_out = it.slot;
				if (it.slot < PoolSlots && slot_live[it.slot]) begin
					r.alive = 1'b1;
					r.pos_x_out = slot_pos[it.slot][0];
					r.pos_y_out = slot_pos[it.slot][1];
					r.pos_z_out = slot_pos[it.slot][2];
					r.color_out = slot_color[it.slot];
					r.life_out = slot_life[it.slot];
					r.size_out = slot_size[it.slot];
					r.kind_out = slot_kind[it.slot];
				end
			end
			default: ;
		endcase
		r.alive_count = live_total[8:0];
	endtask

	task automatic check_field(string name, longint exp_v, longint got_v);
		if (exp_v != got_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, got_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pps_out_t want;
		pps_out_t got;
		if (!arst_n) begin
			for (int i = 0; i < PoolSlots; i++)
				slot_live[i] = 1'b0;
			live_total = 0;
			fail_count = 0;
			expected_results.delete();
		end else begin
			// A result beat always belongs to an earlier command, so match first.
			if (result_valid) begin
				got = result;
				if (expected_results.size() == 0) begin
					$error("result beat with no command outstanding");
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("accepted", want.accepted, got.accepted);
					check_field("slot_out", want.slot_out, got.slot_out);
					check_field("alive", want.alive, got.alive);
					check_field("alive_count", want.alive_count, got.alive_count);
					check_field("pos_x_out", want.pos_x_out, got.pos_x_out);
					check_field("pos_y_out", want.pos_y_out, got.pos_y_out);
					check_field("pos_z_out", want.pos_z_out, got.pos_z_out);
					check_field("color_out", want.color_out, got.color_out);
					check_field("life_out", want.life_out, got.life_out);
					check_field("size_out", want.size_out, got.size_out);
					check_field("kind_out", want.kind_out, got.kind_out);
				end
			end
			if (start && !busy) begin
				predict_pool(in_item, want);
				expected_results.push_back(want);
			end
		end
	end
endmodule

/* sim/tb_top.sv */
// Testbench top for the particle pool block: drives command beats, runs the
// checker beside the block and prints the verdict.
// Depends on pps_pkg, particle_pool_physics_step and pps_checker.
`timescale 1ns / 100ps
module tb_top;
	import pps_pkg::*;

	logic clk;
	logic arst_n;
	logic start;
	pps_in_t in_item;
	logic busy;
	logic result_valid;
	pps_out_t result;
	int unsigned fail_count;
	int unsigned pending;

	// Percentage of commands after which the sender drops start for an idle gap.
	int idle_pct;

	particle_pool_physics_step dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.in_item(in_item),
		.busy(busy),
		.result_valid(result_valid),
		.result(result)
	);

	pps_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.in_item(in_item),
		.result_valid(result_valid),
		.result(result),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop. Even if every command were a full tick over a full pool, the run
	// stays well inside this bound.
	initial begin
		#(600_000_000);
		$display("== FAIL ==");
		$finish;
	end

	// Signed 24-bit value: extremes, small values around the floor, or any.
	function automatic logic [23:0] pick_q24();
		case ($urandom_range(0, 5))
			0: return S24_MAX;
			1: return S24_MIN;
			2, 3: return 24'($signed($urandom_range(0, 16384)) - 8192);
			default: return 24'($urandom);
		endcase
	endfunction

	// Elapsed time for a tick: mostly short steps, with zero and the maximum.
	function automatic logic [15:0] pick_dt();
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom);
			default: return 16'($urandom_range(1, 2048));
		endcase
	endfunction

	// Spawn life: mostly long enough to live through a few ticks.
	function automatic logic [15:0] pick_life();
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(1, 512));
			default: return 16'($urandom_range(2048, 40000));
		endcase
	endfunction

	function automatic pps_in_t spawn_cmd(logic [1:0] kind, logic [15:0] life);
		pps_in_t it;
		it = '0;
		it.action = ACT_SPAWN;
		it.slot = 8'($urandom);
		it.pos_x = pick_q24();
		it.pos_y = pick_q24();
		it.pos_z = pick_q24();
		it.vel_x = pick_q24();
		it.vel_y = pick_q24();
		it.vel_z = pick_q24();
		it.color = $urandom;
		it.time_value = life;
		it.size = 16'($urandom);
		it.kind = kind;
		return it;
	endfunction

	function automatic pps_in_t simple_cmd(logic [1:0] action, logic [7:0] slot,
			logic [15:0] tv);
		pps_in_t it;
		it = spawn_cmd(2'($urandom), 16'($urandom));
		it.action = action;
		it.slot = slot;
		it.time_value = tv;
		return it;
	endfunction

	// Hold one command until the block takes it. Entered and left on a falling
	// edge; without an idle gap start stays high on return, so back-to-back beats need no toggle.
	// An idle gap starts once the block is ready again, so it is really seen.
	task automatic issue(pps_in_t it);
		start = 1'b1;
		in_item = it;
		while (busy) @(negedge clk);
		@(posedge clk);
		@(negedge clk);
		if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
			start = 1'b0;
			while (busy) @(negedge clk);
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	endtask

	// Random traffic. Spawns dominate so the pool fills up, reads land mostly
	// on low slots where the particles live, and ticks move everything.
	task automatic random_traffic(int count);
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45)
				issue(spawn_cmd(2'($urandom), pick_life()));
			else if (pick < 78)
				issue(simple_cmd(ACT_READ, ($urandom_range(0, 3) == 0) ?
					8'($urandom) : 8'($urandom_range(0, 40)), 16'($urandom)));
			else if (pick < 96)
				issue(simple_cmd(ACT_TICK, 8'($urandom), pick_dt()));
			else
				issue(simple_cmd(ACT_NONE, 8'($urandom), 16'($urandom)));
		end
	endtask

	initial begin
		pps_in_t it;
		arst_n = 1'b0;
		start = 1'b0;
		in_item = '0;
		idle_pct = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: every kind, muzzle at the field extremes, a zero life, a drag
		// step long enough to reverse smoke, reads of live and free slots, the unused
		// action, and a tick that empties all.
		it = spawn_cmd(KIND_MUZZLE, 16'hFFFF);
		it.pos_x = S24_MAX; it.pos_y = S24_MAX; it.pos_z = S24_MIN;
		it.vel_x = S24_MAX; it.vel_y = S24_MAX; it.vel_z = S24_MIN;
		it.color = 32'hFFFF_FFFF; it.size = 16'hFFFF;
		issue(it);
		it = spawn_cmd(KIND_SPARK, 16'h4000);
		it.pos_y = 24'sd0; it.vel_y = S24_MIN; it.color = 32'h0; it.size = 16'h0;
		issue(it);
		it = spawn_cmd(KIND_SMOKE, 16'h8000);
		it.vel_x = 24'sd40960; it.vel_y = -24'sd40960; it.vel_z = S24_MAX;
		issue(it);
		it = spawn_cmd(KIND_DEBRIS, 16'h2000);
		it.pos_y = 24'sd300; it.vel_y = -24'sd81920;
		issue(it);
		issue(spawn_cmd(KIND_SPARK, 16'd0));
		for (int s = 0; s < 5; s++)
			issue(simple_cmd(ACT_READ, 8'(s), 16'h0));
		issue(simple_cmd(ACT_READ, 8'd255, 16'hFFFF));
		issue(simple_cmd(ACT_TICK, 8'd0, 16'd0));
		issue(simple_cmd(ACT_READ, 8'd4, 16'd0));
		issue(simple_cmd(ACT_TICK, 8'hFF, 16'h3000));
		for (int s = 0; s < 4; s++)
			issue(simple_cmd(ACT_READ, 8'(s), 16'h0));
		issue(simple_cmd(ACT_NONE, 8'hFF, 16'hFFFF));
		issue(simple_cmd(ACT_TICK, 8'd0, 16'hFFFF));
		issue(simple_cmd(ACT_READ, 8'd0, 16'h0));

		// Hold off until the pool has answered everything so far.
		start = 1'b0;
		wait (pending == 0);
		@(negedge clk);

		// Fill the pool past its size so spawns are refused, look around,
		// then sweep it empty.
		for (int n = 0; n < 260; n++)
			issue(spawn_cmd(2'($urandom), 16'($urandom_range(4096, 65535))));
		issue(simple_cmd(ACT_READ, 8'd255, 16'h0));
		issue(simple_cmd(ACT_TICK, 8'd0, 16'd100));
		issue(simple_cmd(ACT_READ, 8'($urandom), 16'h0));
		issue(simple_cmd(ACT_TICK, 8'd0, 16'hFFFF));

		// Random phases with different sender idling.
		random_traffic(190);
		idle_pct = 65;
		random_traffic(190);
		idle_pct = 30;
		random_traffic(190);
		idle_pct = 0;
		random_traffic(190);

		start = 1'b0;
		wait (pending == 0);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
